// ----- src/xtea_pkg.sv -----
// Shared types, constants and the round mixing function of the XTEA block cipher.
`default_nettype none

package xtea_pkg;

  // Number of XTEA round pairs (two Feistel rounds each) applied to one block.
  localparam int unsigned ROUND_PAIRS = 32;

  // Round constant, kept in its negated form; the forward step is its two's complement.
  localparam logic [31:0] DELTA_NEG = 32'h61C8_8647;
  localparam logic [31:0] DELTA     = 32'h0 - DELTA_NEG;

  // Decryption starts from the sum that encryption ends with.
  localparam logic [63:0] DecProd   = 64'(ROUND_PAIRS) * {32'h0, DELTA};
  localparam logic [31:0] DEC_START = DecProd[31:0];

  // Configuration register file.
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3
  } cfg_reg_e;

  typedef logic [KEY_WORDS-1:0][31:0] key_t;

  // Input request and result payloads.
  typedef struct packed {
    logic        kind;
    logic [31:0] first_word;
    logic [31:0] second_word;
  } in_req_t;

  typedef struct packed {
    logic [31:0] first_result;
    logic [31:0] second_result;
  } out_rsp_t;

  // Data handed from one cell of the round chain to the next.
  typedef struct packed {
    logic        kind;
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] sum;
  } stage_t;

  // Shift-xor-add mixing applied to one half of the block.
  function automatic logic [31:0] mix(input logic [31:0] v);
    mix = ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

`default_nettype wire

// ----- src/xtea_key_regs.sv -----
// Key register file written through the configuration channel.
`default_nettype none

module xtea_key_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [xtea_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_wdata_i,
  output xtea_pkg::key_t                 key_o
);
  import xtea_pkg::*;

  key_t key_q;
  key_t key_d;
  logic cfg_we;

  // Writes are always taken; an index past the key words is dropped.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    key_d = key_q;
    if (cfg_we) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_KEY0: key_d[0] = cfg_wdata_i;
        REG_KEY1: key_d[1] = cfg_wdata_i;
        REG_KEY2: key_d[2] = cfg_wdata_i;
        REG_KEY3: key_d[3] = cfg_wdata_i;
        default:  key_d    = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

  // A write to the first key word lands on the following cycle.
  a_key0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we && cfg_index_i == REG_KEY0) |=> (key_q[0] == $past(cfg_wdata_i)))
    else $error("key word 0 not updated by its write request");

endmodule

`default_nettype wire

// ----- src/xtea_cell.sv -----
// One XTEA cycle of the round chain: two Feistel half-rounds, each behind its own register.
`default_nettype none

module xtea_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  xtea_pkg::key_t   key_i,
  input  logic             valid_i,
  input  xtea_pkg::stage_t data_i,
  output logic             valid_o,
  output xtea_pkg::stage_t data_o
);
  import xtea_pkg::*;

  stage_t mid_q, mid_d;
  stage_t out_q, out_d;
  logic   mid_valid_q;
  logic   out_valid_q;

  logic [31:0] src_a, round_key_a, term_a;
  logic [1:0]  kidx_a;
  logic [31:0] src_b, round_key_b, term_b;
  logic [1:0]  kidx_b;

  // First half: encrypt updates v0 from v1, decrypt peels v1 off using v0.
  always_comb begin
    src_a       = data_i.kind ? data_i.v0 : data_i.v1;
    kidx_a      = data_i.kind ? data_i.sum[12:11] : data_i.sum[1:0];
    round_key_a = data_i.sum + key_i[kidx_a];
    term_a      = mix(src_a) ^ round_key_a;
    mid_d       = data_i;
    if (data_i.kind) begin
      mid_d.v1  = data_i.v1 - term_a;
      mid_d.sum = data_i.sum + DELTA_NEG;
    end else begin
      mid_d.v0  = data_i.v0 + term_a;
      mid_d.sum = data_i.sum - DELTA_NEG;
    end
  end

  // Second half uses the stepped sum and the other word.
  always_comb begin
    src_b       = mid_q.kind ? mid_q.v1 : mid_q.v0;
    kidx_b      = mid_q.kind ? mid_q.sum[1:0] : mid_q.sum[12:11];
    round_key_b = mid_q.sum + key_i[kidx_b];
    term_b      = mix(src_b) ^ round_key_b;
    out_d       = mid_q;
    if (mid_q.kind) begin
      out_d.v0 = mid_q.v0 - term_b;
    end else begin
      out_d.v1 = mid_q.v1 + term_b;
    end
  end

  // Valid flags follow the data; the whole chain moves only when enabled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      mid_valid_q <= valid_i;
      out_valid_q <= mid_valid_q;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= mid_d;
      out_q <= out_d;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  // A request entering the cell reaches its middle register at the next edge.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && valid_i) |=> mid_valid_q)
    else $error("request lost entering cell");

  // Without enable the cell keeps its occupancy.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> ($stable(mid_valid_q) && $stable(out_valid_q)))
    else $error("cell occupancy changed while stalled");

endmodule

`default_nettype wire

// ----- src/xtea_block_cipher.sv -----
// XTEA block cipher: a chain of round cells, one 64-bit block accepted per cycle
// while the chain is not stalled.
// Usage:
//   The key is written as four 32-bit words over the cfg channel (index 0..3,
//   other indexes are dropped); cfg_ready_o is always high. Write it while
//   no request is in flight.
//   A request on in_req_i carries the direction (kind: 0 encrypt, 1 decrypt)
//   and the two data words. It is taken when in_valid_i and in_ready_o are high.
//   The result appears on out_rsp_o with out_valid_o and is taken when
//   out_ready_i is high.
// Throughput:
//   Every request passes through the chain, one register per Feistel
//   half-round, so a new request can be accepted every cycle and results
//   leave at one per cycle while the chain is not stalled.
// Reset and stall:
//   Reset clears the key words and all valid flags; the chain is empty.
//   When a result waits on out_valid_o with out_ready_i low, the whole chain
//   holds and in_ready_o drops until the result is taken.
`default_nettype none

module xtea_block_cipher (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [xtea_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  xtea_pkg::in_req_t              in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output xtea_pkg::out_rsp_t             out_rsp_o
);
  import xtea_pkg::*;

  key_t   key;
  logic   chain_en;
  logic   valid_chain [ROUND_PAIRS+1];
  stage_t data_chain  [ROUND_PAIRS+1];

  xtea_key_regs u_keys (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_o       (key)
  );

  // The chain advances unless a finished result is held by the receiver.
  assign chain_en   = !valid_chain[ROUND_PAIRS] || out_ready_i;
  assign in_ready_o = chain_en;

  // Feed the chain: the starting sum depends on the direction.
  assign valid_chain[0]       = in_valid_i;
  assign data_chain[0].kind   = in_req_i.kind;
  assign data_chain[0].v0     = in_req_i.first_word;
  assign data_chain[0].v1     = in_req_i.second_word;
  assign data_chain[0].sum    = in_req_i.kind ? DEC_START : 32'h0;

  for (genvar g = 0; g < ROUND_PAIRS; g++) begin : g_cells
    xtea_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (chain_en),
      .key_i   (key),
      .valid_i (valid_chain[g]),
      .data_i  (data_chain[g]),
      .valid_o (valid_chain[g+1]),
      .data_o  (data_chain[g+1])
    );
  end

  // The last cell's registers double as the output register.
  assign out_valid_o             = valid_chain[ROUND_PAIRS];
  assign out_rsp_o.first_result  = data_chain[ROUND_PAIRS].v0;
  assign out_rsp_o.second_result = data_chain[ROUND_PAIRS].v1;

  // Input is refused only while a result is pending and not taken.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input refused without a pending result");

endmodule

`default_nettype wire
